>>> rtl/link_setup_handshake_macros.svh
// ---------------------------------------------------------------------------
// link_setup_handshake_macros.svh
// Assertion macros shared by the link setup handshake modules.
// ---------------------------------------------------------------------------
`ifndef LINK_SETUP_HANDSHAKE_MACROS_SVH
`define LINK_SETUP_HANDSHAKE_MACROS_SVH

// same-cycle implication
`define LSH_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsh assertion failed");

// next-cycle implication
`define LSH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsh assertion failed");

`endif

>>> rtl/lsh_pkg.sv
// ---------------------------------------------------------------------------
// lsh_pkg
// Types and constants of the link setup handshake block.
// ---------------------------------------------------------------------------
package lsh_pkg;

   localparam logic [7:0] FRAME_FLAG = 8'h7E;
   localparam logic [7:0] FRAME_ADDR = 8'h03;
   localparam logic [7:0] CTRL_SET   = 8'h03;
   localparam logic [7:0] CTRL_UA    = 8'h07;

   localparam int BEAT_W = 3;
   localparam logic [BEAT_W-1:0] FRAME_LAST_BEAT = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROLE     = 2'd0,
      CSR_TIMEOUT  = 2'd1,
      CSR_ATTEMPTS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_CONN = 2'd2,
      PH_FAIL = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      MS_START = 3'd0,
      MS_FLAG  = 3'd1,
      MS_ADDR  = 3'd2,
      MS_CTRL  = 3'd3,
      MS_BCC   = 3'd4
   } match_type;

   typedef enum logic [1:0] {
      JOB_STATUS = 2'd0,
      JOB_SET    = 2'd1,
      JOB_UA     = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      phase_type    status;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/lsh_front.sv
// ---------------------------------------------------------------------------
// lsh_front
// Accepts items, holds config, runs the SET/UA protocol state and queues
// one job (frame or status beat) per accepted item.
// ---------------------------------------------------------------------------
module lsh_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [7:0]                   req_rx_byte,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lsh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsh_pkg::CSR_DATA_W-1:0]  csr_data,
   input  lsh_pkg::queue_status_type    queue_status,
   output logic                         job_push,
   output lsh_pkg::job_type             job_data
);
   import lsh_pkg::*;

   logic        role_ff;
   logic [15:0] timeout_ff;
   logic [7:0]  max_att_ff;

   phase_type   phase_ff, phase_in;
   match_type   ms_ff, ms_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  att_ff, att_in;

   logic        accept;
   logic [7:0]  ctrl_sel;
   logic [7:0]  expect_byte;
   match_type   ms_step;
   logic        frame_done;
   job_kind_type kind;

   assign csr_ready = 1'b1;
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff    <= 1'b0;
         timeout_ff <= 16'd3;
         max_att_ff <= 8'd3;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROLE:     role_ff    <= csr_data[0];
            CSR_TIMEOUT:  timeout_ff <= csr_data[15:0];
            CSR_ATTEMPTS: max_att_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // frame matcher step on the received byte
   always_comb begin
      ctrl_sel   = role_ff ? CTRL_SET : CTRL_UA;
      ms_step    = MS_START;
      frame_done = 1'b0;
      unique case (ms_ff)
         MS_FLAG: expect_byte = FRAME_ADDR;
         MS_ADDR: expect_byte = ctrl_sel;
         MS_CTRL: expect_byte = FRAME_ADDR ^ ctrl_sel;
         default: expect_byte = FRAME_FLAG;
      endcase
      unique case (ms_ff)
         MS_FLAG, MS_ADDR, MS_CTRL: begin
            if (req_rx_byte == expect_byte) begin
               ms_step = match_type'(ms_ff + 3'd1);
            end else if (req_rx_byte == FRAME_FLAG) begin
               ms_step = MS_FLAG;
            end
         end
         MS_BCC: begin
            frame_done = (req_rx_byte == FRAME_FLAG);
         end
         default: begin
            if (req_rx_byte == FRAME_FLAG) ms_step = MS_FLAG;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      ms_in    = ms_ff;
      wait_in  = wait_ff;
      att_in   = att_ff;
      kind     = JOB_STATUS;
      if (op_type'(req_opcode) == OP_START) begin
         ms_in   = MS_START;
         wait_in = 16'd0;
         att_in  = 8'd0;
         if (role_ff) begin
            phase_in = PH_WAIT;
         end else if (max_att_ff == 8'd0) begin
            phase_in = PH_FAIL;
         end else begin
            att_in   = 8'd1;
            wait_in  = timeout_ff;
            phase_in = PH_WAIT;
            kind     = JOB_SET;
         end
      end else if (role_ff) begin
         if (op_type'(req_opcode) == OP_BYTE &&
             (phase_ff == PH_WAIT || phase_ff == PH_CONN)) begin
            ms_in = ms_step;
            if (frame_done) begin
               phase_in = PH_CONN;
               kind     = JOB_UA;
            end
         end
      end else if (phase_ff == PH_WAIT) begin
         if (op_type'(req_opcode) == OP_BYTE) begin
            ms_in = ms_step;
            if (frame_done) begin
               phase_in = PH_CONN;
               wait_in  = 16'd0;
            end
         end else if (op_type'(req_opcode) == OP_TICK) begin
            if (wait_ff > 16'd1) begin
               wait_in = wait_ff - 16'd1;
            end else if (att_ff < max_att_ff) begin
               // timeout: resend SET
               att_in   = att_ff + 8'd1;
               wait_in  = timeout_ff;
               ms_in    = MS_START;
               kind     = JOB_SET;
            end else begin
               wait_in  = 16'd0;
               phase_in = PH_FAIL;
               ms_in    = MS_START;
            end
         end
      end
   end

   assign job_push        = accept;
   assign job_data.kind   = kind;
   assign job_data.status = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ms_ff    <= MS_START;
         wait_ff  <= 16'd0;
         att_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         ms_ff    <= ms_in;
         wait_ff  <= wait_in;
         att_ff   <= att_in;
      end
   end

endmodule

>>> rtl/lsh_queue.sv
// ---------------------------------------------------------------------------
// lsh_queue
// Short job queue between the protocol front end and the frame emitter.
// ---------------------------------------------------------------------------
`include "link_setup_handshake_macros.svh"

module lsh_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lsh_pkg::job_type          push_data,
   input  logic                      pop,
   output lsh_pkg::job_type          pop_data,
   output lsh_pkg::queue_status_type status
);
   import lsh_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign status.full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   `LSH_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `LSH_ASSERT_NOW(a_no_push_full, clock, reset, status.full, !push)
   `LSH_ASSERT_NOW(a_ptr_gap, clock, reset, status.empty || status.full, wr_ff == rd_ff)

endmodule

>>> rtl/lsh_back.sv
// ---------------------------------------------------------------------------
// lsh_back
// Pops jobs and drives the result register: five frame beats for SET/UA,
// one status beat otherwise.
// ---------------------------------------------------------------------------
`include "link_setup_handshake_macros.svh"

module lsh_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lsh_pkg::queue_status_type queue_status,
   input  lsh_pkg::job_type          job_data,
   output logic                      job_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_tx_valid,
   output logic                      rsp_last_of_run,
   output logic [1:0]                rsp_link_status
);
   import lsh_pkg::*;

   function automatic logic [7:0] frame_byte(input logic [7:0] ctrl,
                                             input logic [BEAT_W-1:0] idx);
      logic [7:0] r;
      case (idx)
         3'd1:    r = FRAME_ADDR;
         3'd2:    r = ctrl;
         3'd3:    r = FRAME_ADDR ^ ctrl;
         default: r = FRAME_FLAG;
      endcase
      return r;
   endfunction

   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              txv_ff, txv_in;
   logic              last_ff, last_in;
   phase_type         stat_ff, stat_in;
   logic              active_ff, active_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [7:0]        ctrl_ff, ctrl_in;
   phase_type         cur_stat_ff, cur_stat_in;
   logic              load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      txv_in      = txv_ff;
      last_in     = last_ff;
      stat_in     = stat_ff;
      active_in   = active_ff;
      beat_in     = beat_ff;
      ctrl_in     = ctrl_ff;
      cur_stat_in = cur_stat_ff;
      job_pop     = 1'b0;
      if (load) begin
         if (active_ff) begin
            valid_in  = 1'b1;
            byte_in   = frame_byte(ctrl_ff, beat_ff);
            txv_in    = 1'b1;
            last_in   = (beat_ff == FRAME_LAST_BEAT);
            stat_in   = cur_stat_ff;
            beat_in   = beat_ff + 1'b1;
            active_in = (beat_ff != FRAME_LAST_BEAT);
         end else if (!queue_status.empty) begin
            job_pop  = 1'b1;
            valid_in = 1'b1;
            stat_in  = job_data.status;
            if (job_data.kind == JOB_STATUS) begin
               byte_in = 8'd0;
               txv_in  = 1'b0;
               last_in = 1'b1;
            end else begin
               ctrl_in     = (job_data.kind == JOB_UA) ? CTRL_UA : CTRL_SET;
               cur_stat_in = job_data.status;
               byte_in     = FRAME_FLAG;
               txv_in      = 1'b1;
               last_in     = 1'b0;
               beat_in     = 3'd1;
               active_in   = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
         beat_ff   <= '0;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
         beat_ff   <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      txv_ff      <= txv_in;
      last_ff     <= last_in;
      stat_ff     <= stat_in;
      ctrl_ff     <= ctrl_in;
      cur_stat_ff <= cur_stat_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_tx_byte     = byte_ff;
   assign rsp_tx_valid    = txv_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_link_status = stat_ff;

   `LSH_ASSERT_NOW(a_active_beat, clock, reset, active_ff, beat_ff != 3'd0 && beat_ff <= FRAME_LAST_BEAT)
   `LSH_ASSERT_NEXT(a_frame_runs, clock, reset, valid_ff && !rsp_stall && !last_ff, valid_ff && txv_ff)
   `LSH_ASSERT_NOW(a_no_pop_mid, clock, reset, active_ff, !job_pop)

endmodule

>>> rtl/link_setup_handshake.sv
// ---------------------------------------------------------------------------
// link_setup_handshake
// SET/UA link establishment over a byte link with supervisory frames.
// ---------------------------------------------------------------------------
// Input channel (req_): one beat per received byte, time tick or start.
// Result channel (rsp_): an item that sends SET or UA yields five beats
// (7E 03 ctrl bcc 7E); any other item yields one status beat with
// tx_valid low. last_of_run marks the final beat of each item and
// link_status gives the phase after that item.
// Config (csr_): index 0 role, 1 timeout ticks, 2 max attempts; always ready,
// to be written by the user only while idle; the block does not enforce it.
// An accepted item's job enters the job queue at the accept edge, and its
// first result beat is then registered from the queue. Protocol state
// updates at the accept edge, so items are taken one per cycle while the
// job queue is not full; a four-entry job queue sits between the front end
// and the frame emitter, which sends one beat per cycle while rsp_stall is
// low; a valid result beat holds while rsp_stall is high. req_stall rises
// once the job queue is full. Synchronous reset returns to idle, role
// transmitter, timeout 3, max attempts 3, and empties the queue.
// ---------------------------------------------------------------------------
module link_setup_handshake (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_opcode,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_tx_valid,
   output logic                            rsp_last_of_run,
   output logic [1:0]                      rsp_link_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lsh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsh_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lsh_pkg::*;

   queue_status_type q_status;
   logic             push, pop;
   job_type          push_job, pop_job;

   lsh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_rx_byte  (req_rx_byte),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_status (q_status),
      .job_push     (push),
      .job_data     (push_job)
   );

   lsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .status    (q_status)
   );

   lsh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (q_status),
      .job_data        (pop_job),
      .job_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_link_status (rsp_link_status)
   );

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for link_setup_handshake. An item-level model of the
// SET/UA handshake predicts every result beat. A monitor compares each
// accepted beat against the oldest prediction. Directed tests cover retry,
// failure, link-up and receiver answers. Randomized traffic follows, mostly
// whole frames, idling at random on both channels except in its last setup.
// ---------------------------------------------------------------------------
module tb;
   import lsh_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;

   // opcode with no meaning; the block answers it with a status beat
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       last;
      logic [1:0] status;
   } link_beat_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_opcode;
   logic [7:0]             req_rx_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [7:0]             rsp_tx_byte;
   logic                   rsp_tx_valid;
   logic                   rsp_last_of_run;
   logic [1:0]             rsp_link_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   link_beat_type expected_beats[$];

   // model state and registers
   logic        m_role;
   logic [15:0] m_timeout;
   logic [7:0]  m_max_tries;
   phase_type   m_phase;
   match_type   m_match;
   logic [15:0] m_wait;
   logic [7:0]  m_tries;

   bit idle_enable;
   int fail_count;
   int items_sent;
   int beats_checked;
   int frames_seen;
   int csr_writes;
   int cycle_count;
   int stall_left;

   link_setup_handshake i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_link_status (rsp_link_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver back-pressure in random bursts
   always @(posedge clock) begin
      if (idle_enable && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 12);
      if (idle_enable && stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end
   end

   // sampled mid-cycle: a beat seen here is taken at the next rising edge
   always @(negedge clock) begin
      link_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (rsp_tx_valid && rsp_last_of_run)
            frames_seen++;
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: tx_byte %0h", rsp_tx_byte);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %0h, actual %0h", want.tx_byte, rsp_tx_byte);
               fail_count++;
            end
            if (rsp_tx_valid !== want.tx_valid) begin
               $error("tx_valid: expected %0d, actual %0d", want.tx_valid, rsp_tx_valid);
               fail_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, actual %0d", want.last, rsp_last_of_run);
               fail_count++;
            end
            if (rsp_link_status !== want.status) begin
               $error("link_status: expected %0d, actual %0d", want.status, rsp_link_status);
               fail_count++;
            end
         end
      end
   end

   // ---------------- model ----------------

   function automatic void reset_link_model();
      m_role      = 1'b0;
      m_timeout   = 16'd3;
      m_max_tries = 8'd3;
      m_phase     = PH_IDLE;
      m_match     = MS_START;
      m_wait      = '0;
      m_tries     = '0;
   endfunction

   function automatic void push_frame(input logic [7:0] ctrl);
      logic [7:0] frame_bytes [5];
      frame_bytes = '{FRAME_FLAG, FRAME_ADDR, ctrl, FRAME_ADDR ^ ctrl, FRAME_FLAG};
      for (int k = 0; k < 5; k++)
         expected_beats.push_back('{frame_bytes[k], 1'b1, (k == 4), m_phase});
   endfunction

   function automatic void push_status();
      expected_beats.push_back('{8'h00, 1'b0, 1'b1, m_phase});
   endfunction

   // one byte into the frame matcher; returns 1 when a frame completes
   function automatic bit advance_matcher(input logic [7:0] b, input logic [7:0] ctrl);
      logic [7:0] want;
      match_type  nxt;
      bit         done;
      nxt  = MS_START;
      done = 1'b0;
      case (m_match)
         MS_FLAG: want = FRAME_ADDR;
         MS_ADDR: want = ctrl;
         MS_CTRL: want = FRAME_ADDR ^ ctrl;
         default: want = FRAME_FLAG;
      endcase
      if (m_match inside {MS_FLAG, MS_ADDR, MS_CTRL}) begin
         if (b == want)
            nxt = match_type'(m_match + 3'd1);
         else if (b == FRAME_FLAG)
            nxt = MS_FLAG;
      end else if (m_match == MS_BCC) begin
         if (b == FRAME_FLAG)
            done = 1'b1;
      end else if (b == FRAME_FLAG) begin
         nxt = MS_FLAG;
      end
      m_match = nxt;
      return done;
   endfunction

   function automatic void send_set_frame();
      m_tries = m_tries + 8'd1;
      m_wait  = m_timeout;
      m_match = MS_START;
      m_phase = PH_WAIT;
      push_frame(CTRL_SET);
   endfunction

   function automatic void predict_link_response(input logic [1:0] op, input logic [7:0] b);
      if (op == OP_START) begin
         m_match = MS_START;
         m_wait  = '0;
         m_tries = '0;
         if (m_role) begin
            m_phase = PH_WAIT;
            push_status();
         end else if (m_max_tries == 0) begin
            m_phase = PH_FAIL;
            push_status();
         end else begin
            send_set_frame();
         end
      end else if (m_role) begin
         if (op == OP_BYTE && (m_phase == PH_WAIT || m_phase == PH_CONN)
             && advance_matcher(b, CTRL_SET)) begin
            m_phase = PH_CONN;
            push_frame(CTRL_UA);
         end else begin
            push_status();
         end
      end else if (m_phase != PH_WAIT) begin
         push_status();
      end else if (op == OP_BYTE) begin
         if (advance_matcher(b, CTRL_UA)) begin
            m_phase = PH_CONN;
            m_wait  = '0;
         end
         push_status();
      end else if (op == OP_TICK) begin
         if (m_wait > 1) begin
            m_wait = m_wait - 16'd1;
            push_status();
         end else begin
            m_wait = '0;
            if (m_tries < m_max_tries) begin
               send_set_frame();
            end else begin
               m_phase = PH_FAIL;
               m_match = MS_START;
               push_status();
            end
         end
      end else begin
         push_status();
      end
   endfunction

   // ---------------- drivers ----------------

   task automatic send_link_item(input logic [1:0] op, input logic [7:0] b);
      bit stalled;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      predict_link_response(op, b);
      items_sent++;
   endtask

   task automatic send_frame(input logic [7:0] ctrl, input bit corrupt);
      logic [7:0] frame_bytes [5];
      int         bad;
      frame_bytes = '{FRAME_FLAG, FRAME_ADDR, ctrl, FRAME_ADDR ^ ctrl, FRAME_FLAG};
      bad = corrupt ? $urandom_range(0, 4) : -1;
      for (int k = 0; k < 5; k++)
         send_link_item(OP_BYTE, (k == bad) ? 8'($urandom_range(0, 255)) : frame_bytes[k]);
   endtask

   // stop sending and wait until every predicted beat has been taken
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      bit ready_seen;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(negedge clock);
         ready_seen = csr_ready;
         @(posedge clock);
      end while (!ready_seen);
      case (idx)
         CSR_ROLE:     m_role = value[0];
         CSR_TIMEOUT:  m_timeout = value;
         CSR_ATTEMPTS: m_max_tries = value[7:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic role, input logic [15:0] ticks, input logic [7:0] tries);
      settle();
      write_csr(CSR_ROLE, {15'd0, role});
      write_csr(CSR_TIMEOUT, ticks);
      write_csr(CSR_ATTEMPTS, {8'd0, tries});
   endtask

   // ---------------- tests ----------------

   // zero timeout behaves as one tick; two attempts then failure
   task automatic test_tx_retry_limit();
      configure(1'b0, 16'd0, 8'd2);
      send_link_item(OP_START, 8'h00);
      send_link_item(OP_TICK, 8'h00);
      send_link_item(OP_TICK, 8'hFF);
      send_link_item(OP_BYTE, 8'hFF);
      send_link_item(OP_UNUSED, 8'h00);
   endtask

   task automatic test_tx_zero_attempts();
      configure(1'b0, 16'd3, 8'd0);
      send_link_item(OP_START, 8'hFF);
   endtask

   // noise and a doubled flag ahead of a good UA, then restart while connected
   task automatic test_tx_link_up();
      configure(1'b0, 16'd2, 8'd255);
      send_link_item(OP_START, 8'h00);
      send_link_item(OP_BYTE, 8'h00);
      send_link_item(OP_BYTE, FRAME_FLAG);
      send_frame(CTRL_UA, 1'b0);
      send_link_item(OP_TICK, 8'h00);
      send_link_item(OP_START, 8'h00);
   endtask

   task automatic test_rx_answer();
      configure(1'b1, 16'd3, 8'd3);
      send_link_item(OP_START, 8'h00);
      send_frame(CTRL_SET, 1'b0);
      send_frame(CTRL_SET, 1'b0);
      send_link_item(OP_TICK, 8'h00);
   endtask

   // role flips while connected: phase is kept
   task automatic test_role_switch();
      settle();
      write_csr(CSR_ROLE, 16'd0);
      send_link_item(OP_TICK, 8'h00);
      send_link_item(OP_BYTE, FRAME_FLAG);
   endtask

   task automatic drive_random_traffic(input int item_goal);
      int first;
      int pick;
      first = items_sent;
      while (items_sent - first < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)
            settle();
         else if (pick < 42)
            send_frame(m_role ? CTRL_SET : CTRL_UA, $urandom_range(0, 3) == 0);
         else if (pick < 50)
            send_frame(m_role ? CTRL_UA : CTRL_SET, 1'b0);
         else if (pick < 70)
            repeat ($urandom_range(1, 4)) send_link_item(OP_TICK, 8'($urandom));
         else if (pick < 78)
            send_link_item(OP_START, 8'($urandom));
         else if (pick < 94)
            send_link_item(OP_BYTE, 8'($urandom_range(0, 255)));
         else
            send_link_item(OP_UNUSED, 8'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      logic        role;
      logic [15:0] ticks;
      logic [7:0]  tries;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin role = 1'b0; ticks = 16'd1; tries = 8'd1; end
            1: begin role = 1'b0; ticks = 16'hFFFF; tries = 8'd255; end
            2: begin role = 1'b1; ticks = 16'($urandom_range(0, 5)); tries = 8'd2; end
            default: begin
               role  = 1'($urandom_range(0, 1));
               ticks = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
               tries = 8'($urandom_range(0, 5));
            end
         endcase
         configure(role, ticks, tries);
         if (p == 5)
            idle_enable = 1'b0;
         send_link_item(OP_START, 8'($urandom));
         drive_random_traffic(45);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = '0;
      req_rx_byte = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      idle_enable = 1'b1;
      fail_count  = 0;
      items_sent  = 0;
      beats_checked = 0;
      frames_seen = 0;
      csr_writes  = 0;
      cycle_count = 0;
      stall_left  = 0;
      reset_link_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_tx_retry_limit();
      test_tx_zero_attempts();
      test_tx_link_up();
      test_rx_answer();
      test_role_switch();
      test_random_traffic();

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d predicted beats never arrived", expected_beats.size());
         fail_count++;
      end
      $display("Run: %0d items, %0d beats checked, %0d frames, %0d register writes.",
               items_sent, beats_checked, frames_seen, csr_writes);
      $display("Both roles, retry/fail/link-up paths, timeout 0..65535, attempts 0..255.");
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
